FILE: rtl/infix_to_postfix_converter_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// Shared concurrent-assertion forms, sampled on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication
`define IFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ifp assertion failed");

// Next-cycle implication
`define IFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ifp assertion failed");

`endif

FILE: rtl/ifp_pkg.sv
// ---------------------------------------------------------------------------
// ifp_pkg
// Types, constants and character helpers of the infix to postfix converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ifp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int SYM_W       = 8;
  localparam int USER_W      = 4;

  localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [SYM_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_UNCLOSED  = 2'd3
  } status_t;

  // One result item as held in the pending and output registers
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             has;
    logic             done;
    status_t          status;
  } res_t;

  // Operator precedence, zero for anything that is not an operator
  function automatic logic [1:0] prec_of(input logic [SYM_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_CARET) p = 2'd3;
    else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    else if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    return p;
  endfunction

  // Letters and digits
  function automatic logic is_operand(input logic [SYM_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ifp_ram.sv
// ---------------------------------------------------------------------------
// ifp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/infix_to_postfix_converter_top.sv
// ---------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: infix characters in, postfix characters and an
// end-of-expression status item out. The operator stack lives in a RAM.
// ---------------------------------------------------------------------------
// Channel  Dir  tdata          tuser                        tlast
// in_      in   symbol[7:0]    -                            end_of_input
// out_     out  out_symbol     has_symbol, done, status     last_of_run
//
// Operand, '(' and ignored characters pass through IDLE and FIN; an operator
// adds OPCHK, which pops one entry per step; ')' adds UNRD and UNCHK, which pop
// one operator per step. An end item adds the flush through UNRD and UNCHK, then
// DONE (only DONE if an error is pending). The pace is set by the single stack
// RAM: one read per cycle while the output does not stall.
// After reset the S_INIT state writes the '(' sentinel before the first item.
// A full output register stalls only the steps that emit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "infix_to_postfix_converter_top_macros.svh"

module infix_to_postfix_converter_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [ifp_pkg::SYM_W-1:0]   in_tdata,   // [7:0] symbol
  input  wire logic                        in_tlast,   // end_of_input
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [ifp_pkg::SYM_W-1:0]   out_tdata,  // [7:0] out_symbol
  output logic      [ifp_pkg::USER_W-1:0]  out_tuser,  // [0] has_symbol,
                                                       // [1] expression_done,
                                                       // [3:2] status
  output logic                             out_tlast   // last_of_run
);

  import ifp_pkg::*;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_OPCHK = 7'b0000100,
    S_UNRD  = 7'b0001000,
    S_UNCHK = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  status_t            err_r, err_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               eoi_r, eoi_nxt;
  logic               flush_r, flush_nxt;
  res_t               pend_r, pend_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  res_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_last_r, out_last_nxt;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [SYM_W-1:0]   wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [SYM_W-1:0]   rd_data;

  logic               out_free;
  logic               can_emit;
  logic               emit;
  res_t               emit_res;
  logic               go_post;
  logic               unw_done;
  logic               unw_ok;
  logic [LEVEL_W-1:0] lvl_m1;
  logic [LEVEL_W-1:0] lvl_m2;
  logic [1:0]         top_prec;

  // Operator stack
  ifp_ram #(
    .WIDTH (SYM_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || out_tready;
  assign can_emit = !pend_valid_r || out_free;
  assign lvl_m1   = level_r - LEVEL_W'(1);
  assign lvl_m2   = level_r - LEVEL_W'(2);
  assign top_prec = prec_of(rd_data);

  // Sequence one item through the stack
  always_comb begin
    state_nxt      = state_r;
    level_nxt      = level_r;
    err_nxt        = err_r;
    sym_nxt        = sym_r;
    eoi_nxt        = eoi_r;
    flush_nxt      = flush_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    emit           = 1'b0;
    emit_res       = '0;
    go_post        = 1'b0;
    unw_done       = 1'b0;
    unw_ok         = 1'b0;

    case (state_r)
      S_INIT: begin
        wr_en     = 1'b1;
        wr_data   = CH_LPAREN;
        level_nxt = LEVEL_W'(1);
        err_nxt   = ST_OK;
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_tvalid) begin
          sym_nxt   = in_tdata;
          eoi_nxt   = in_tlast;
          flush_nxt = 1'b0;
          if (err_r != ST_OK) begin
            go_post = 1'b1;
          end else if (is_operand(in_tdata)) begin
            emit     = 1'b1;
            emit_res = '{sym: in_tdata, has: 1'b1, done: 1'b0, status: ST_OK};
            go_post  = 1'b1;
          end else if (in_tdata == CH_LPAREN) begin
            if (level_r == LEVEL_W'(STACK_DEPTH)) begin
              err_nxt = ST_OVERFLOW;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = level_r[ADDR_W-1:0];
              wr_data   = in_tdata;
              level_nxt = level_r + LEVEL_W'(1);
            end
            go_post = 1'b1;
          end else if (prec_of(in_tdata) != 2'd0) begin
            if (level_r == '0) begin
              err_nxt = ST_UNDERFLOW;
              go_post = 1'b1;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = lvl_m1[ADDR_W-1:0];
              state_nxt = S_OPCHK;
            end
          end else if (in_tdata == CH_RPAREN) begin
            state_nxt = S_UNRD;
          end else begin
            go_post = 1'b1;
          end
        end
      end

      // Compare the stack top against the incoming operator
      S_OPCHK: begin
        if (top_prec == 2'd0 || top_prec < prec_of(sym_r)) begin
          if (level_r == LEVEL_W'(STACK_DEPTH)) begin
            if (err_nxt == ST_OK) err_nxt = ST_OVERFLOW;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = level_r[ADDR_W-1:0];
            wr_data   = sym_r;
            level_nxt = level_r + LEVEL_W'(1);
          end
          go_post = 1'b1;
        end else if (can_emit) begin
          emit     = 1'b1;
          emit_res = '{sym: rd_data, has: 1'b1, done: 1'b0, status: ST_OK};
          if (level_r == LEVEL_W'(1)) begin
            // stack ran empty: push into the bottom slot
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = sym_r;
            level_nxt = LEVEL_W'(1);
            go_post   = 1'b1;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = lvl_m2[ADDR_W-1:0];
            level_nxt = lvl_m1;
          end
        end
      end

      // Start an unwind to the nearest '('
      S_UNRD: begin
        if (level_r == '0) begin
          if (err_nxt == ST_OK) err_nxt = ST_UNDERFLOW;
          unw_done = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = lvl_m1[ADDR_W-1:0];
          level_nxt = lvl_m1;
          state_nxt = S_UNCHK;
        end
      end

      S_UNCHK: begin
        if (rd_data == CH_LPAREN) begin
          unw_done = 1'b1;
          unw_ok   = 1'b1;
        end else if (can_emit) begin
          emit     = 1'b1;
          emit_res = '{sym: rd_data, has: 1'b1, done: 1'b0, status: ST_OK};
          if (level_r == '0) begin
            if (err_nxt == ST_OK) err_nxt = ST_UNDERFLOW;
            unw_done = 1'b1;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = lvl_m1[ADDR_W-1:0];
            level_nxt = lvl_m1;
          end
        end
      end

      // Emit the done item and reinitialize the stack
      S_DONE: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_res  = '{sym: '0, has: 1'b0, done: 1'b1, status: err_r};
          wr_en     = 1'b1;
          wr_data   = CH_LPAREN;
          level_nxt = LEVEL_W'(1);
          err_nxt   = ST_OK;
          state_nxt = S_FIN;
        end
      end

      // Release the held item as the last of its run
      S_FIN: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt        = pend_r;
          out_last_nxt   = 1'b1;
          out_valid_nxt  = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase

    // Finish an unwind
    if (unw_done) begin
      if (flush_r) begin
        if (unw_ok && level_nxt != '0 && err_nxt == ST_OK) err_nxt = ST_UNCLOSED;
        state_nxt = S_DONE;
      end else begin
        go_post = 1'b1;
      end
    end

    // End of item: flush on the last character (straight to DONE on an error), else release
    if (go_post) begin
      if (eoi_nxt) begin
        if (err_nxt != ST_OK) begin
          state_nxt = S_DONE;
        end else begin
          flush_nxt = 1'b1;
          state_nxt = S_UNRD;
        end
      end else begin
        state_nxt = S_FIN;
      end
    end

    // Hold each new result in the pending register so its last flag is known on release
    if (emit) begin
      if (pend_valid_r) begin
        out_nxt       = pend_r;
        out_last_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      pend_nxt       = emit_res;
      pend_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      level_r      <= LEVEL_W'(1);
      err_r        <= ST_OK;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      level_r      <= level_nxt;
      err_r        <= err_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    eoi_r      <= eoi_nxt;
    flush_r    <= flush_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.sym;
  assign out_tuser  = {out_r.status, out_r.done, out_r.has};
  assign out_tlast  = out_last_r;

  `IFP_ASSERT_NOW(a_no_rw_overlap, rd_en, !wr_en)
  `IFP_ASSERT_NOW(a_level_range, 1'b1, level_r <= LEVEL_W'(STACK_DEPTH))
  `IFP_ASSERT_NOW(a_idle_no_pending, in_tready, !pend_valid_r)
  `IFP_ASSERT_NOW(a_done_is_last, out_tvalid && out_tuser[1], out_tlast)
  `IFP_ASSERT_NEXT(a_reinit, state_r == S_DONE && can_emit,
                   level_r == LEVEL_W'(1) && err_r == ST_OK)

endmodule

`default_nettype wire
